>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, switched off while reset is asserted
`define HPE_ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Concurrent assertion checked at every clock edge, reset included
`define HPE_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

>>> rtl/hpe_pkg.sv
// ----------------------------------------------------------------------------
// hpe_pkg
// Shared types and constants of the Horner polynomial evaluator.
// ----------------------------------------------------------------------------
package hpe_pkg;

    // Q16.16 data word and coefficient count widths
    localparam int DATA_W  = 32;
    localparam int PROD_W  = 2 * DATA_W;
    localparam int COUNT_W = 3;
    localparam int INDEX_W = 3;

    // Coefficient registers in the register map
    localparam int NUM_COEF_REGS = 7;

    // Register indexes
    localparam logic [INDEX_W-1:0] REG_COEF_COUNT = 3'd0;
    localparam logic [INDEX_W-1:0] REG_COEF_0     = 3'd1;

    // Saturation limits
    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

    // Data carried from cell to cell
    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] acc;
        logic                     ovf;
    } hpe_lane_t;

endpackage

>>> rtl/horner_polynomial_evaluator.sv
// ----------------------------------------------------------------------------
// horner_polynomial_evaluator
// Evaluates a polynomial in signed Q16.16 by Horner's rule on a chain of
// multiply-add cells, one cell per coefficient, highest coefficient first.
//
//  Channel   Direction  Contents
//  s_*       in         arg_x (tdata[31:0])
//  m_*       out        value_y (tdata[31:0]), overflow (tuser[0])
//  cfg_*     in         coef_count (index 0), coef_0..coef_6 (index 1..7)
//
// One transaction accepted per cycle while the result is not stalled, with two
// register stages (multiply, then add and saturate) in each cell.
// Reset clears the coefficient registers and all stage valid bits.
// A stalled output holds its result; a stage advances whenever the stage
// after it is empty or moving, so bubbles close up under a stall.
// ----------------------------------------------------------------------------
module horner_polynomial_evaluator #(
    parameter int MAX_COEFS = 7,
    parameter int FRAC_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // s_tdata: [31:0] arg_x
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [hpe_pkg::DATA_W-1:0]     s_tdata,
    // m_tdata: [31:0] value_y
    // m_tuser: [0] overflow
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [hpe_pkg::DATA_W-1:0]     m_tdata,
    output logic [0:0]                     m_tuser,
    input  logic                           cfg_we,
    input  logic [hpe_pkg::INDEX_W-1:0]    cfg_index,
    input  logic [hpe_pkg::DATA_W-1:0]     cfg_wdata
);
    import hpe_pkg::*;

    logic [COUNT_W-1:0]       coef_count_reg;
    logic signed [DATA_W-1:0] coef_reg [NUM_COEF_REGS];
    logic [COUNT_W-1:0]       count_clip;

    logic                     valid_chain [MAX_COEFS+1];
    logic                     ready_chain [MAX_COEFS+1];
    hpe_lane_t                lane_chain  [MAX_COEFS+1];

    // Take configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_count_reg <= '0;
            for (int i = 0; i < NUM_COEF_REGS; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_COEF_COUNT)
            begin
                coef_count_reg <= cfg_wdata[COUNT_W-1:0];
            end
            else
            begin
                coef_reg[cfg_index - REG_COEF_0] <= cfg_wdata;
            end
        end
    end

    // Clip the count to the cells present
    assign count_clip = (coef_count_reg > COUNT_W'(MAX_COEFS)) ?
                        COUNT_W'(MAX_COEFS) : coef_count_reg;

    // Feed the chain head
    assign valid_chain[0]     = s_tvalid;
    assign s_tready           = ready_chain[0];
    assign lane_chain[0].x    = s_tdata;
    assign lane_chain[0].acc  = '0;
    assign lane_chain[0].ovf  = 1'b0;

    // One cell per coefficient, highest index first
    for (genvar k = 0; k < MAX_COEFS; k++)
    begin : g_cell
        hpe_cell #(
            .COEF_IDX  (MAX_COEFS - 1 - k),
            .FRAC_BITS (FRAC_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .coef_count (count_clip),
            .coef       (coef_reg[MAX_COEFS - 1 - k]),
            .in_valid   (valid_chain[k]),
            .in_ready   (ready_chain[k]),
            .lane_in    (lane_chain[k]),
            .out_valid  (valid_chain[k+1]),
            .out_ready  (ready_chain[k+1]),
            .lane_out   (lane_chain[k+1])
        );
    end

    // Drive the result port from the last cell
    assign m_tvalid               = valid_chain[MAX_COEFS];
    assign ready_chain[MAX_COEFS] = m_tready;
    assign m_tdata                = lane_chain[MAX_COEFS].acc;
    assign m_tuser[0]             = lane_chain[MAX_COEFS].ovf;

endmodule

>>> rtl/hpe_cell.sv
// ----------------------------------------------------------------------------
// hpe_cell
// One Horner step: multiply the running value by x, then add one coefficient
// with saturation. Two register stages, with valid/ready between cells.
// ----------------------------------------------------------------------------
module hpe_cell #(
    parameter int COEF_IDX  = 0,
    parameter int FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [hpe_pkg::COUNT_W-1:0]         coef_count,
    input  logic signed [hpe_pkg::DATA_W-1:0]   coef,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  hpe_pkg::hpe_lane_t                  lane_in,
    output logic                                out_valid,
    input  logic                                out_ready,
    output hpe_pkg::hpe_lane_t                  lane_out
);
    import hpe_pkg::*;

    // Count at which this cell loads its coefficient as the start value
    localparam logic [COUNT_W-1:0] LOAD_COUNT = COUNT_W'(COEF_IDX + 1);

    logic                     a_valid_reg;
    hpe_lane_t                a_lane_reg;
    logic signed [PROD_W-1:0] a_prod_reg;
    logic signed [PROD_W-1:0] prod;
    logic                     en_a;

    logic                     b_valid_reg;
    hpe_lane_t                b_lane_reg;
    hpe_lane_t                b_lane_next;
    logic                     en_b;

    logic signed [PROD_W-1:0] sum;
    logic                     pos_ovf;
    logic                     neg_ovf;

    // Advance a stage when it is empty or its successor advances
    assign en_b     = !b_valid_reg || out_ready;
    assign en_a     = !a_valid_reg || en_b;
    assign in_ready = en_a;

    // Stage A: full signed product of running value and x
    assign prod = lane_in.acc * lane_in.x;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (en_a)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_a && in_valid)
        begin
            a_lane_reg <= lane_in;
            a_prod_reg <= prod;
        end
    end

    // Stage B: load the coefficient, or truncate, add coefficient, saturate; else pass through
    assign sum     = (a_prod_reg >>> FRAC_BITS) + PROD_W'(coef);
    assign pos_ovf = !sum[PROD_W-1] && (|sum[PROD_W-2:DATA_W-1]);
    assign neg_ovf = sum[PROD_W-1] && !(&sum[PROD_W-2:DATA_W-1]);

    always_comb
    begin
        b_lane_next = a_lane_reg;
        priority if (coef_count == LOAD_COUNT)
        begin
            b_lane_next.acc = coef;
        end
        else if (coef_count > LOAD_COUNT)
        begin
            if (pos_ovf)
            begin
                b_lane_next.acc = Q_MAX;
                b_lane_next.ovf = 1'b1;
            end
            else if (neg_ovf)
            begin
                b_lane_next.acc = Q_MIN;
                b_lane_next.ovf = 1'b1;
            end
            else
            begin
                b_lane_next.acc = sum[DATA_W-1:0];
            end
        end
        else
        begin
            b_lane_next = a_lane_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (en_b)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_b && a_valid_reg)
        begin
            b_lane_reg <= b_lane_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign lane_out  = b_lane_reg;

endmodule

>>> rtl/hpe_checker.sv
// ----------------------------------------------------------------------------
// hpe_checker
// Port-level checks of the Horner evaluator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hpe_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [hpe_pkg::DATA_W-1:0]     s_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [hpe_pkg::DATA_W-1:0]     m_tdata,
    input  logic [0:0]                     m_tuser,
    input  logic                           cfg_we,
    input  logic [hpe_pkg::INDEX_W-1:0]    cfg_index,
    input  logic [hpe_pkg::DATA_W-1:0]     cfg_wdata
);
    import hpe_pkg::*;

    logic count_small_reg;

    // Track whether at most one coefficient is in use
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_small_reg <= 1'b1;
        end
        else if (cfg_we && (cfg_index == REG_COEF_COUNT))
        begin
            count_small_reg <= (cfg_wdata[COUNT_W-1:0] < COUNT_W'(2));
        end
    end

    // No result is shown in the cycle after a reset edge
    `HPE_ASSERT_ALWAYS(a_no_out_in_reset, clk, !rst_n |=> !m_tvalid)

    // A stalled result holds
    `HPE_ASSERT_RST(a_out_hold, clk, rst_n,
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // An offered argument holds until it is taken
    `HPE_ASSERT_RST(a_in_hold, clk, rst_n, s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))

    // An empty or draining output never blocks the input
    `HPE_ASSERT_RST(a_in_ready, clk, rst_n, (!m_tvalid || m_tready) |-> s_tready)

    // No multiply-add step runs with zero or one coefficient
    `HPE_ASSERT_RST(a_no_ovf_const, clk, rst_n, m_tvalid && count_small_reg |-> !m_tuser[0])

endmodule

bind horner_polynomial_evaluator hpe_checker u_hpe_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
);
